>>> rtl/core/vspg_pkg.sv
// ----------------------------------------------------------------------------
// vspg_pkg
// shared types and constants of the scan-line pixel generator
// ----------------------------------------------------------------------------
package vspg_pkg;

   localparam int DEFAULT_RAM_DEPTH = 32768;

   localparam int ADDR_W       = 16;
   localparam int RAM_ADDR_W   = 15;
   localparam int BYTE_W       = 8;
   localparam int PAL_INDEX_W  = 4;
   localparam int COLOR_W      = 3;
   localparam int LINE_W       = 8;
   localparam int GROUP_W      = 7;
   localparam int PIXELS       = 8;
   localparam int PIXELS_W     = PIXELS * COLOR_W;
   localparam int PALETTE_DEPTH = 16;
   localparam int MODE_W       = 3;
   localparam int STEP_W       = GROUP_W + 3;

   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = ADDR_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_MODE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDRESS = 1'd1;

   localparam logic [MODE_W-1:0] MODE_1BPP      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_2BPP      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_4BPP      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_GAP_1BPP  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_WIDE_1BPP = 3'd6;

   localparam logic [MODE_W-1:0] MODE_RESET  = MODE_1BPP;
   localparam logic [ADDR_W-1:0] START_RESET = 16'h4000;

   localparam logic [COLOR_W-1:0] COLOR_BLACK = 3'd7;

   // address layout
   localparam logic [ADDR_W-1:0] ROW_BYTES_LOW  = 16'h0280;
   localparam logic [ADDR_W-1:0] ROW_BYTES_GAP  = 16'h0240;
   localparam logic [ADDR_W-1:0] ROW_BYTES_WIDE = 16'h0140;
   localparam logic [ADDR_W-1:0] DEFAULT_START  = 16'h3000;
   localparam logic [ADDR_W-1:0] LOW_LIMIT      = 16'h8000;
   localparam logic [ADDR_W-1:0] LOW_WRAP_ADD   = 16'h3000;
   localparam logic [ADDR_W-1:0] LOW_WRAP_MASK  = 16'h7fff;
   localparam logic [ADDR_W-1:0] LOW_STEP_SUB   = LOW_LIMIT - LOW_WRAP_ADD;
   localparam logic [ADDR_W-1:0] GAP_LIMIT      = 16'h7e40;
   localparam logic [ADDR_W-1:0] GAP_MODULUS    = 16'h3e40;
   localparam logic [ADDR_W-1:0] GAP_BASE       = 16'h4000;
   localparam logic [ADDR_W-1:0] GAP_MOD_X2     = 16'(2 * 16'h3e40);
   localparam logic [ADDR_W-1:0] GAP_MOD_X3     = 16'(3 * 16'h3e40);
   localparam logic [ADDR_W-1:0] GAP_MOD_X4     = 16'(4 * 16'h3e40);
   localparam logic [ADDR_W-1:0] GAP_STEP_SUB   = GAP_MOD_X2 - GAP_BASE;
   localparam logic [ADDR_W-1:0] WIDE_LIMIT     = 16'h7f40;
   localparam logic [ADDR_W-1:0] WIDE_RESTART   = 16'h6000;
   localparam logic [ADDR_W-1:0] WIDE_STEP_SUB  = WIDE_LIMIT - WIDE_RESTART;

   localparam int                LINES_PER_ROW  = 10;
   localparam int                DIV10_MUL      = 205;
   localparam int                DIV10_SHIFT    = 11;
   localparam logic [LINE_W-1:0] WIDE_LAST_LINE = 8'd250;
   localparam logic [3:0]        GAP_FIRST_LINE = 4'd8;

   typedef enum logic [1:0] {
      OP_WRITE_RAM     = 2'd0,
      OP_WRITE_PALETTE = 2'd1,
      OP_DRAW          = 2'd2
   } op_type;

   typedef logic [PALETTE_DEPTH-1:0][COLOR_W-1:0] palette_type;

endpackage

>>> rtl/core/vspg_req_if.sv
// ----------------------------------------------------------------------------
// vspg_req_if
// request channel: ram and palette writes, pixel group draws
// ----------------------------------------------------------------------------
interface vspg_req_if;
   logic                                valid;
   logic                                ready;
   vspg_pkg::op_type                    op;
   logic [vspg_pkg::RAM_ADDR_W-1:0]     ram_address;
   logic [vspg_pkg::BYTE_W-1:0]         ram_data;
   logic [vspg_pkg::PAL_INDEX_W-1:0]    palette_index;
   logic [vspg_pkg::COLOR_W-1:0]        physical_color;
   logic [vspg_pkg::LINE_W-1:0]         line;
   logic [vspg_pkg::GROUP_W-1:0]        group;

   modport source (output valid, op, ram_address, ram_data, palette_index,
                   physical_color, line, group, input ready);
   modport sink   (input valid, op, ram_address, ram_data, palette_index,
                   physical_color, line, group, output ready);
endinterface

>>> rtl/core/vspg_rsp_if.sv
// ----------------------------------------------------------------------------
// vspg_rsp_if
// response channel: one pixel group per beat
// ----------------------------------------------------------------------------
interface vspg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [vspg_pkg::PIXELS_W-1:0]     pixels;
   logic                              drawn;

   modport source (output valid, pixels, drawn, input ready);
   modport sink   (input valid, pixels, drawn, output ready);
endinterface

>>> rtl/core/vspg_pixel_decode.sv
// ----------------------------------------------------------------------------
// vspg_pixel_decode
// screen byte to eight physical colours through the palette
// ----------------------------------------------------------------------------
module vspg_pixel_decode (
   input  logic [vspg_pkg::MODE_W-1:0]   mode,
   input  logic                          gap,
   input  logic                          odd_group,
   input  logic [vspg_pkg::BYTE_W-1:0]   data,
   input  vspg_pkg::palette_type         palette,
   output logic [vspg_pkg::PIXELS_W-1:0] pixels,
   output logic                          drawn
);
   import vspg_pkg::*;

   always_comb begin : decode
      logic [PAL_INDEX_W-1:0] idx;
      logic [COLOR_W-1:0]     colour;
      int                     j;
      pixels = '0;
      drawn  = 1'b0;
      for (int k = 0; k < PIXELS; k++) begin
         j   = 0;
         idx = '0;
         case (mode)
            MODE_1BPP, MODE_GAP_1BPP: begin
               idx = {3'b000, data[7-k]};
            end
            MODE_2BPP: begin
               j   = k / 2;
               idx = {2'b00, data[7-j], data[3-j]};
            end
            MODE_4BPP: begin
               j   = k / 4;
               idx = {data[7-j], data[5-j], data[3-j], data[1-j]};
            end
            MODE_WIDE_1BPP: begin
               j   = (odd_group ? 4 : 0) + k / 2;
               idx = {3'b000, data[7-j]};
            end
            default: begin
               idx = '0;
            end
         endcase
         colour = gap ? COLOR_BLACK : palette[idx];
         pixels[COLOR_W*k +: COLOR_W] = colour;
      end
      case (mode)
         MODE_1BPP, MODE_2BPP, MODE_4BPP, MODE_GAP_1BPP, MODE_WIDE_1BPP: begin
            drawn = 1'b1;
         end
         default: begin
            drawn  = 1'b0;
            pixels = '0;
         end
      endcase
   end

endmodule

>>> rtl/core/video_scanline_pixel_generator.sv
// ----------------------------------------------------------------------------
// video_scanline_pixel_generator
// screen ram, palette and pixel group fetch for one scan line position
// ----------------------------------------------------------------------------
// req beats carry one op each: a screen ram byte write, a palette entry
// write, or a draw of one 8-pixel group of a given line and group. only a
// draw gives a rsp beat: eight 3-bit colours, leftmost in the low bits, and
// a drawn flag that is low in the modes without a bitmap.
// csr writes set the display mode and the screen start address; change them
// only while nothing is in flight.
// a beat goes through a four-deep pipeline: line to row address, start wrap,
// group step and screen ram access (one port, registered read), then
// palette decode into the rsp register. a draw passes p1, p2, p3 and the rsp
// register in turn. one req beat per cycle while rsp is not held; ram and
// palette writes take effect in order with the draws around them.
// reset clears the pipeline, sets mode 0, start 0x4000 and the palette to
// black for colour 0 and colour 0 elsewhere; screen ram is not cleared.
// while rsp is held, the whole pipeline holds and req.ready falls with it.
// ----------------------------------------------------------------------------
module video_scanline_pixel_generator #(
   parameter int RAM_DEPTH = vspg_pkg::DEFAULT_RAM_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   vspg_req_if.sink                           req,
   vspg_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [vspg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [vspg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import vspg_pkg::*;

   localparam int AW = $clog2(RAM_DEPTH);

   // configuration
   logic [MODE_W-1:0] mode_ff,  mode_in;
   logic [ADDR_W-1:0] start_ff, start_in;

   // pipeline
   logic                   advance;
   logic                   p1_valid_ff, p2_valid_ff, p3_valid_ff;
   op_type                 p1_op_ff, p2_op_ff, p3_op_ff;
   logic [ADDR_W-1:0]      p1_base_ff, p1_base_in;
   logic                   p1_gap_ff, p1_gap_in, p2_gap_ff, p3_gap_ff;
   logic [GROUP_W-1:0]     p1_group_ff, p2_group_ff;
   logic                   p3_odd_ff;
   logic [RAM_ADDR_W-1:0]  p1_waddr_ff, p2_waddr_ff;
   logic [BYTE_W-1:0]      p1_wdata_ff, p2_wdata_ff;
   logic [PAL_INDEX_W-1:0] p1_pidx_ff, p2_pidx_ff, p3_pidx_ff;
   logic [COLOR_W-1:0]     p1_pcol_ff, p2_pcol_ff, p3_pcol_ff;
   logic [RAM_ADDR_W-1:0]  p2_start_ff, p2_start_in;

   // stage 0 helpers
   logic [15:0]        div_prod;
   logic [4:0]         row10;
   logic [LINE_W-1:0]  row10_x10;
   logic [3:0]         sub10;
   logic [ADDR_W-1:0]  start_eff;

   // stage 2 helpers
   logic [STEP_W-1:0]     step;
   logic [ADDR_W-1:0]     stepped;
   logic [RAM_ADDR_W-1:0] fetch_addr;
   logic [AW-1:0]         ram_addr;

   // storage
   logic [BYTE_W-1:0] screen_ram [RAM_DEPTH];
   logic [BYTE_W-1:0] rd_ff;
   palette_type       palette_ff, palette_in;

   // output
   logic                rsp_valid_ff;
   logic [PIXELS_W-1:0] rsp_pixels_ff, pixels_dec;
   logic                rsp_drawn_ff, drawn_dec;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.pixels = rsp_pixels_ff;
   assign rsp.drawn  = rsp_drawn_ff;

   // configuration registers
   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DISPLAY_MODE:  mode_in  = csr_wdata[MODE_W-1:0];
            CSR_START_ADDRESS: start_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RESET;
         start_ff <= START_RESET;
      end else begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
      end
   end

   // stage 0: row address of the line
   assign div_prod  = 16'(req.line) * 16'(DIV10_MUL);
   assign row10     = div_prod[15:DIV10_SHIFT];
   assign row10_x10 = 8'(row10) * 8'(LINES_PER_ROW);
   assign sub10     = 4'(req.line - row10_x10);
   assign start_eff = (start_ff != '0) ? start_ff : DEFAULT_START;

   always_comb begin
      case (mode_ff)
         MODE_1BPP, MODE_2BPP, MODE_4BPP: begin
            p1_base_in = 16'(req.line[7:3]) * ROW_BYTES_LOW
                       + 16'(req.line[2:0]) + start_eff;
         end
         MODE_GAP_1BPP: begin
            p1_base_in = 16'(row10) * ROW_BYTES_GAP + 16'(sub10) + start_ff;
         end
         MODE_WIDE_1BPP: begin
            p1_base_in = 16'(row10) * ROW_BYTES_WIDE + 16'(sub10) + start_ff;
         end
         default: begin
            p1_base_in = '0;
         end
      endcase
      p1_gap_in = ((mode_ff == MODE_GAP_1BPP) && (sub10 >= GAP_FIRST_LINE))
               || ((mode_ff == MODE_WIDE_1BPP)
                   && ((sub10 >= GAP_FIRST_LINE) || (req.line >= WIDE_LAST_LINE)));
   end

   // stage 1: wrap of the line start
   always_comb begin
      case (mode_ff)
         MODE_1BPP, MODE_2BPP, MODE_4BPP: begin
            if (p1_base_ff >= LOW_LIMIT) begin
               p2_start_in = RAM_ADDR_W'((p1_base_ff + LOW_WRAP_ADD) & LOW_WRAP_MASK);
            end else begin
               p2_start_in = RAM_ADDR_W'(p1_base_ff);
            end
         end
         MODE_GAP_1BPP: begin
            if (p1_base_ff >= GAP_MOD_X4) begin
               p2_start_in = RAM_ADDR_W'(p1_base_ff - GAP_MOD_X4 + GAP_BASE);
            end else if (p1_base_ff >= GAP_MOD_X3) begin
               p2_start_in = RAM_ADDR_W'(p1_base_ff - GAP_MOD_X3 + GAP_BASE);
            end else if (p1_base_ff >= GAP_LIMIT) begin
               p2_start_in = RAM_ADDR_W'(p1_base_ff - GAP_MOD_X2 + GAP_BASE);
            end else begin
               p2_start_in = RAM_ADDR_W'(p1_base_ff);
            end
         end
         MODE_WIDE_1BPP: begin
            if (p1_base_ff >= WIDE_LIMIT) begin
               p2_start_in = RAM_ADDR_W'(WIDE_RESTART);
            end else begin
               p2_start_in = RAM_ADDR_W'(p1_base_ff);
            end
         end
         default: begin
            p2_start_in = '0;
         end
      endcase
   end

   // stage 2: group step, at most one wrap within a line
   always_comb begin
      if (mode_ff == MODE_WIDE_1BPP) begin
         step = {1'b0, p2_group_ff[GROUP_W-1:1], 3'b000};
      end else begin
         step = {p2_group_ff, 3'b000};
      end
      stepped = 16'(p2_start_ff) + 16'(step);
      case (mode_ff)
         MODE_1BPP, MODE_2BPP, MODE_4BPP: begin
            fetch_addr = (stepped >= LOW_LIMIT) ? RAM_ADDR_W'(stepped - LOW_STEP_SUB)
                                                : RAM_ADDR_W'(stepped);
         end
         MODE_GAP_1BPP: begin
            fetch_addr = (stepped >= GAP_LIMIT) ? RAM_ADDR_W'(stepped - GAP_STEP_SUB)
                                                : RAM_ADDR_W'(stepped);
         end
         MODE_WIDE_1BPP: begin
            fetch_addr = (stepped >= WIDE_LIMIT) ? RAM_ADDR_W'(stepped - WIDE_STEP_SUB)
                                                 : RAM_ADDR_W'(stepped);
         end
         default: begin
            fetch_addr = RAM_ADDR_W'(stepped);
         end
      endcase
      if (p2_op_ff == OP_WRITE_RAM) begin
         ram_addr = AW'(p2_waddr_ff);
      end else begin
         ram_addr = AW'(fetch_addr);
      end
   end

   // screen ram, single port
   always_ff @(posedge clock) begin
      if (advance && p2_valid_ff) begin
         if (p2_op_ff == OP_WRITE_RAM) begin
            screen_ram[ram_addr] <= p2_wdata_ff;
         end
         rd_ff <= screen_ram[ram_addr];
      end
   end

   // stage 3: palette write and decode
   always_comb begin
      palette_in = palette_ff;
      if (advance && p3_valid_ff && (p3_op_ff == OP_WRITE_PALETTE)) begin
         palette_in[p3_pidx_ff] = p3_pcol_ff;
      end
   end

   vspg_pixel_decode u_decode (
      .mode      (mode_ff),
      .gap       (p3_gap_ff),
      .odd_group (p3_odd_ff),
      .data      (rd_ff),
      .palette   (palette_ff),
      .pixels    (pixels_dec),
      .drawn     (drawn_dec)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         palette_ff   <= {{((PALETTE_DEPTH-1)*COLOR_W){1'b0}}, COLOR_BLACK};
      end else begin
         palette_ff <= palette_in;
         if (advance) begin
            p1_valid_ff  <= req.valid;
            p2_valid_ff  <= p1_valid_ff;
            p3_valid_ff  <= p2_valid_ff;
            rsp_valid_ff <= p3_valid_ff && (p3_op_ff == OP_DRAW);
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_op_ff      <= req.op;
         p1_base_ff    <= p1_base_in;
         p1_gap_ff     <= p1_gap_in;
         p1_group_ff   <= req.group;
         p1_waddr_ff   <= req.ram_address;
         p1_wdata_ff   <= req.ram_data;
         p1_pidx_ff    <= req.palette_index;
         p1_pcol_ff    <= req.physical_color;

         p2_op_ff      <= p1_op_ff;
         p2_start_ff   <= p2_start_in;
         p2_gap_ff     <= p1_gap_ff;
         p2_group_ff   <= p1_group_ff;
         p2_waddr_ff   <= p1_waddr_ff;
         p2_wdata_ff   <= p1_wdata_ff;
         p2_pidx_ff    <= p1_pidx_ff;
         p2_pcol_ff    <= p1_pcol_ff;

         p3_op_ff      <= p2_op_ff;
         p3_gap_ff     <= p2_gap_ff;
         p3_odd_ff     <= p2_group_ff[0];
         p3_pidx_ff    <= p2_pidx_ff;
         p3_pcol_ff    <= p2_pcol_ff;

         rsp_pixels_ff <= pixels_dec;
         rsp_drawn_ff  <= drawn_dec;
      end
   end

   // checks
   a_undrawn_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_drawn_ff |-> rsp_pixels_ff == '0)
      else $error("undrawn group carries pixels");

   a_draw_reaches_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && p3_valid_ff && (p3_op_ff == OP_DRAW) |=> rsp_valid_ff)
      else $error("draw lost at the rsp register");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({p1_valid_ff, p2_valid_ff, p3_valid_ff}))
      else $error("pipeline moved during a stall");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && p3_valid_ff && (p3_op_ff != OP_DRAW) |=> !rsp_valid_ff)
      else $error("write op produced a rsp beat");

endmodule

>>> verif/tb_video_scanline_pixel_generator.sv
// ----------------------------------------------------------------------------
// tb_video_scanline_pixel_generator
// self-checking bench for the scan-line pixel generator
// ----------------------------------------------------------------------------
// req beats are queued per display setting: a few edge-case draws, then
// sweeps of groups along a line, single draws, palette and screen ram writes
// and ignored ops. any draw whose byte has not been written yet gets a
// screen ram write queued ahead of it. a shadow copy of ram, palette and
// settings predicts each pixel group when its req beat is taken, and every
// rsp beat is checked in order against that prediction. both sides idle at
// random, and the receiver once holds off long enough to back up the req side.
// ----------------------------------------------------------------------------
module tb_video_scanline_pixel_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import vspg_pkg::*;

   localparam int  RAM_DEPTH         = DEFAULT_RAM_DEPTH;
   localparam int  PHASE_COUNT       = 16;
   localparam int  RANDOM_PHASES     = 3;
   localparam int  ITEMS_PER_PHASE   = 55;
   localparam int  SETTLE_CYCLES     = 8;
   localparam int  HOLD_AFTER_GROUPS = 40;
   localparam int  HOLD_CYCLES       = 300;

   localparam logic [1:0]        OP_UNUSED   = 2'd3;
   localparam logic [MODE_W-1:0] MODE_BLANK4 = 3'd4;
   localparam logic [MODE_W-1:0] MODE_BLANK5 = 3'd5;
   localparam logic [MODE_W-1:0] MODE_BLANK7 = 3'd7;

   typedef struct packed {
      op_type                   op;
      logic [RAM_ADDR_W-1:0]    ram_address;
      logic [BYTE_W-1:0]        ram_data;
      logic [PAL_INDEX_W-1:0]   palette_index;
      logic [COLOR_W-1:0]       physical_color;
      logic [LINE_W-1:0]        line;
      logic [GROUP_W-1:0]       group;
   } gen_beat_type;

   typedef struct packed {
      logic [PIXELS_W-1:0] pixels;
      logic                drawn;
   } draw_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   gen_beat_type src_item   = '0;
   logic         src_valid  = 1'b0;
   logic         sink_ready = 1'b0;

   vspg_req_if req_bus();
   vspg_rsp_if rsp_bus();

   assign req_bus.valid          = src_valid;
   assign req_bus.op             = src_item.op;
   assign req_bus.ram_address    = src_item.ram_address;
   assign req_bus.ram_data       = src_item.ram_data;
   assign req_bus.palette_index  = src_item.palette_index;
   assign req_bus.physical_color = src_item.physical_color;
   assign req_bus.line           = src_item.line;
   assign req_bus.group          = src_item.group;
   assign rsp_bus.ready          = sink_ready;

   video_scanline_pixel_generator #(
      .RAM_DEPTH (RAM_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // shadow state
   logic [MODE_W-1:0]  cfg_mode  = MODE_RESET;
   logic [ADDR_W-1:0]  cfg_start = START_RESET;
   logic [BYTE_W-1:0]  ram_shadow [RAM_DEPTH];
   logic [COLOR_W-1:0] colour_map [PALETTE_DEPTH];
   bit                 ram_written [RAM_DEPTH];

   gen_beat_type    beat_queue [$];
   draw_result_type groups_due [$];
   int              beats_queued = 0;
   int              beats_taken  = 0;
   int              mismatches   = 0;

   function automatic int wrap_low(int a);
      a = a & 32'hffff;
      if (a >= LOW_LIMIT)
         a = (a + LOW_WRAP_ADD) & LOW_WRAP_MASK;
      return a;
   endfunction

   function automatic int wrap_gap(int a);
      a = a & 32'hffff;
      if (a >= GAP_LIMIT)
         a = (a % GAP_MODULUS) + GAP_BASE;
      return a;
   endfunction

   // byte fetched for a draw, -1 when no ram read takes place
   function automatic int fetch_address(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] start,
                                        logic [LINE_W-1:0] ln, logic [GROUP_W-1:0] grp);
      int l = ln;
      int g = grp;
      int s = start;
      int a;
      case (mode)
         MODE_1BPP, MODE_2BPP, MODE_4BPP: begin
            if (s == 0)
               s = DEFAULT_START;
            a = wrap_low((l / 8) * ROW_BYTES_LOW + l % 8 + s);
            for (int i = 0; i < g; i++)
               a = wrap_low(a + 8);
         end
         MODE_GAP_1BPP: begin
            if (l % LINES_PER_ROW >= GAP_FIRST_LINE)
               return -1;
            a = wrap_gap((l / LINES_PER_ROW) * ROW_BYTES_GAP + l % LINES_PER_ROW + s);
            for (int i = 0; i < g; i++)
               a = wrap_gap(a + 8);
         end
         MODE_WIDE_1BPP: begin
            if (l % LINES_PER_ROW >= GAP_FIRST_LINE || l >= WIDE_LAST_LINE)
               return -1;
            a = ((l / LINES_PER_ROW) * ROW_BYTES_WIDE + l % LINES_PER_ROW + s) & 32'hffff;
            if (a >= WIDE_LIMIT)
               a = WIDE_RESTART;
            for (int i = 0; i < g / 2; i++) begin
               a = (a + 8) & 32'hffff;
               if (a >= WIDE_LIMIT)
                  a = a - WIDE_STEP_SUB;
            end
         end
         default: return -1;
      endcase
      return a % RAM_DEPTH;
   endfunction

   function automatic draw_result_type predict_group(logic [LINE_W-1:0] ln,
                                                     logic [GROUP_W-1:0] grp);
      draw_result_type res;
      int adr;
      int j;
      logic [BYTE_W-1:0] c;
      logic [PAL_INDEX_W-1:0] idx;
      res.pixels = '0;
      res.drawn  = 1'b1;
      adr = fetch_address(cfg_mode, cfg_start, ln, grp);
      case (cfg_mode)
         MODE_BLANK4, MODE_BLANK5, MODE_BLANK7: res.drawn = 1'b0;
         default: begin
            if (adr < 0) begin
               res.pixels = {PIXELS{COLOR_BLACK}};
            end else begin
               c = ram_shadow[adr];
               for (int k = 0; k < PIXELS; k++) begin
                  case (cfg_mode)
                     MODE_2BPP: begin
                        j = k / 2;
                        idx = {2'b00, c[7-j], c[3-j]};
                     end
                     MODE_4BPP: begin
                        j = k / 4;
                        idx = {c[7-j], c[5-j], c[3-j], c[1-j]};
                     end
                     MODE_WIDE_1BPP: begin
                        j = 4 * int'(grp[0]) + k / 2;
                        idx = {3'b000, c[7-j]};
                     end
                     default: idx = {3'b000, c[7-k]};
                  endcase
                  res.pixels[COLOR_W*k +: COLOR_W] = colour_map[idx];
               end
            end
         end
      endcase
      return res;
   endfunction

   function automatic int draw_idle(inout int run_left, inout int ceiling);
      if (run_left == 0) begin
         run_left = $urandom_range(1, 40);
         case ($urandom_range(0, 2))
            0:       ceiling = 0;
            1:       ceiling = 3;
            default: ceiling = 11;
         endcase
      end
      run_left--;
      return $urandom_range(0, ceiling);
   endfunction

   function automatic gen_beat_type random_beat();
      gen_beat_type b;
      b.op             = OP_DRAW;
      b.ram_address    = RAM_ADDR_W'($urandom_range(0, 32767));
      b.ram_data       = BYTE_W'($urandom_range(0, 255));
      b.palette_index  = PAL_INDEX_W'($urandom_range(0, 15));
      b.physical_color = COLOR_W'($urandom_range(0, 7));
      b.line           = LINE_W'($urandom_range(0, 255));
      b.group          = GROUP_W'($urandom_range(0, 127));
      return b;
   endfunction

   task automatic push_beat(gen_beat_type b);
      if (b.op == OP_WRITE_RAM)
         ram_written[b.ram_address] = 1'b1;
      beat_queue.push_back(b);
      beats_queued++;
   endtask

   task automatic push_ram_write(int adr, int data);
      gen_beat_type b;
      b = random_beat();
      b.op          = OP_WRITE_RAM;
      b.ram_address = RAM_ADDR_W'(adr);
      b.ram_data    = BYTE_W'(data);
      push_beat(b);
   endtask

   task automatic push_palette(int index, int colour);
      gen_beat_type b;
      b = random_beat();
      b.op             = OP_WRITE_PALETTE;
      b.palette_index  = PAL_INDEX_W'(index);
      b.physical_color = COLOR_W'(colour);
      push_beat(b);
   endtask

   task automatic push_draw(int ln, int grp);
      gen_beat_type b;
      int adr;
      b = random_beat();
      b.line  = LINE_W'(ln);
      b.group = GROUP_W'(grp);
      adr = fetch_address(cfg_mode, cfg_start, b.line, b.group);
      if (adr >= 0 && !ram_written[adr])
         push_ram_write(adr, $urandom_range(0, 255));
      push_beat(b);
   endtask

   task automatic push_noise();
      gen_beat_type b;
      b = random_beat();
      b.op = op_type'(OP_UNUSED);
      push_beat(b);
   endtask

   task automatic wait_idle();
      while (beats_taken != beats_queued || groups_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] start);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_DISPLAY_MODE;
      csr_wdata <= CSR_DATA_W'(mode);
      cfg_mode = mode;
      @(posedge clock);
      csr_index <= CSR_START_ADDRESS;
      csr_wdata <= start;
      cfg_start = start;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_random_phase();
      int n;
      int ln;
      int grp;
      int len;
      int pick;
      n = 0;
      push_draw(0, 0);
      push_draw(255, 127);
      push_draw(9, 3);
      push_draw(250, 1);
      while (n < ITEMS_PER_PHASE) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            ln  = $urandom_range(0, 255);
            grp = $urandom_range(0, 127);
            len = $urandom_range(1, 12);
            for (int i = 0; i < len && grp + i <= 127; i++) begin
               push_draw(ln, grp + i);
               n++;
            end
         end else if (pick < 60) begin
            push_draw($urandom_range(0, 255), $urandom_range(0, 127));
            n++;
         end else if (pick < 72) begin
            push_palette($urandom_range(0, 15), $urandom_range(0, 7));
            n++;
         end else if (pick < 92) begin
            push_ram_write($urandom_range(0, 32767), $urandom_range(0, 255));
            n++;
         end else begin
            push_noise();
         end
      end
   endtask

   // request driver
   int src_wait    = 0;
   int src_run     = 0;
   int src_ceiling = 0;

   always @(posedge clock) begin : req_driver
      if (reset) begin
         src_valid <= 1'b0;
         src_wait = 0;
         for (int i = 0; i < PALETTE_DEPTH; i++)
            colour_map[i] = (i == 0) ? COLOR_BLACK : '0;
      end else begin
         if (src_valid && req_bus.ready) begin
            case (src_item.op)
               OP_WRITE_RAM:     ram_shadow[src_item.ram_address] = src_item.ram_data;
               OP_WRITE_PALETTE: colour_map[src_item.palette_index] = src_item.physical_color;
               OP_DRAW:          groups_due.push_back(predict_group(src_item.line,
                                                                    src_item.group));
               default: ;
            endcase
            beats_taken++;
         end
         if (!src_valid || req_bus.ready) begin
            if (src_wait != 0) begin
               src_wait--;
               src_valid <= 1'b0;
            end else if (beat_queue.size() != 0) begin
               src_item  <= beat_queue.pop_front();
               src_valid <= 1'b1;
               src_wait = draw_idle(src_run, src_ceiling);
            end else begin
               src_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   int sink_wait    = 0;
   int sink_run     = 0;
   int sink_ceiling = 0;
   int hold_left    = 0;
   int groups_seen  = 0;

   always @(posedge clock) begin : rsp_monitor
      draw_result_type want;
      if (reset) begin
         sink_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && sink_ready) begin
            if (groups_due.size() == 0) begin
               $display("%0t: unexpected rsp beat: expected none, actual pixels %h drawn %b",
                        $time, rsp_bus.pixels, rsp_bus.drawn);
               mismatches++;
            end else begin
               want = groups_due.pop_front();
               if (rsp_bus.pixels !== want.pixels) begin
                  $display("%0t: pixels mismatch: expected %h, actual %h",
                           $time, want.pixels, rsp_bus.pixels);
                  mismatches++;
               end
               if (rsp_bus.drawn !== want.drawn) begin
                  $display("%0t: drawn mismatch: expected %b, actual %b",
                           $time, want.drawn, rsp_bus.drawn);
                  mismatches++;
               end
            end
            groups_seen++;
            sink_wait = draw_idle(sink_run, sink_ceiling);
            // long hold-off so the pipeline backs up into req
            if (groups_seen == HOLD_AFTER_GROUPS)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            sink_ready <= 1'b0;
         end else if (sink_wait != 0) begin
            sink_wait--;
            sink_ready <= 1'b0;
         end else begin
            sink_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [MODE_W-1:0] phase_mode [PHASE_COUNT];
      logic [ADDR_W-1:0] phase_start [PHASE_COUNT];
      phase_mode  = '{MODE_1BPP, MODE_2BPP, MODE_4BPP, MODE_GAP_1BPP,
                      MODE_WIDE_1BPP, MODE_BLANK4, MODE_1BPP, MODE_2BPP,
                      MODE_4BPP, MODE_GAP_1BPP, MODE_WIDE_1BPP, MODE_BLANK5,
                      MODE_GAP_1BPP, MODE_WIDE_1BPP, MODE_BLANK7, MODE_GAP_1BPP};
      phase_start = '{16'h0000, 16'hffff, 16'h3000, 16'h4000,
                      16'h6000, 16'hffff, 16'h7fff, 16'h0000,
                      16'h8000, 16'hffff, 16'hffff, 16'h0000,
                      16'h0000, 16'h7f40, 16'h4000, 16'h7e40};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings and reset palette first
      push_noise();
      push_ram_write(0, 8'h00);
      push_ram_write(32767, 8'hff);
      push_draw(0, 0);
      push_draw(255, 127);
      push_draw(7, 79);
      push_draw(8, 80);
      push_palette(15, 7);
      push_palette(1, 5);
      push_palette(0, 0);
      push_draw(0, 0);
      push_draw(100, 40);
      push_draw(255, 127);
      wait_idle();

      for (int p = 0; p < PHASE_COUNT + RANDOM_PHASES; p++) begin
         if (p < PHASE_COUNT)
            write_settings(phase_mode[p], phase_start[p]);
         else
            write_settings(MODE_W'($urandom_range(0, 7)), ADDR_W'($urandom_range(0, 65535)));
         push_random_phase();
         wait_idle();
      end

      if (mismatches == 0)
         $display("tb_video_scanline_pixel_generator: done, clean");
      else
         $display("tb_video_scanline_pixel_generator: done, errors");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb_video_scanline_pixel_generator: done, errors");
      $finish;
   end

endmodule
